// ===== src/sog_pkg.sv =====
package sog_pkg;

  localparam int GRID_MAX_SIDE = 64;
  localparam int BEAM_COUNT    = 360;

  localparam int COORD_W = $clog2(GRID_MAX_SIDE);
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int CELLS   = GRID_MAX_SIDE * GRID_MAX_SIDE;
  localparam int SIDE_W  = $clog2(GRID_MAX_SIDE) + 1;

  localparam int RANGE_W = 16;
  localparam int BEAM_W  = 9;
  localparam int ANGLE_W = 10;
  localparam int TRIG_W  = 15;
  localparam int VALUE_W = 8;

  // quotient of range * trig * side / (range_max * 2^16) stays below 2^DIV_STEPS
  localparam int DIV_STEPS = 5;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int RS_W      = RANGE_W + SIDE_W;
  localparam int NUM_W     = RS_W + TRIG_W;
  localparam int DIV_W     = RANGE_W + 16 + DIV_STEPS - 1;

  localparam logic signed [VALUE_W-1:0] CELL_OCCUPIED = 8'sd99;
  localparam logic signed [VALUE_W-1:0] CELL_UNKNOWN  = -8'sd1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 3'd3;

  typedef struct packed {
    logic [RANGE_W-1:0]        range_max_mm;
    logic [RANGE_W-1:0]        cell_size_mm;
    logic [SIDE_W-1:0]         grid_side;
    logic signed [ANGLE_W-1:0] rot_offset;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [BEAM_W-1:0]  beam_index;
    logic [RANGE_W-1:0] range_mm;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;
  } in_item_t;

  typedef struct packed {
    logic                      marked;
    logic [COORD_W-1:0]        cell_x;
    logic [COORD_W-1:0]        cell_y;
    logic signed [VALUE_W-1:0] cell_value;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ANGLE,
    OP_TRIG,
    OP_MUL,
    OP_DIV,
    OP_FIN,
    OP_MARK,
    OP_READ,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic              load;
    dp_op_t            op;
    logic              axis;
    logic [ADDR_W-1:0] clr_addr;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_range;
  } dp_stat_t;

  typedef struct packed {
    logic              neg;
    logic [TRIG_W-1:0] mag;
  } trig_t;

  function automatic logic [TRIG_W-1:0] sine_q15(input logic [6:0] d);
    logic [TRIG_W-1:0] v;
    case (d)
      7'd0:  v = 15'd0;     7'd1:  v = 15'd572;   7'd2:  v = 15'd1144;
      7'd3:  v = 15'd1715;  7'd4:  v = 15'd2286;  7'd5:  v = 15'd2856;
      7'd6:  v = 15'd3425;  7'd7:  v = 15'd3993;  7'd8:  v = 15'd4560;
      7'd9:  v = 15'd5126;  7'd10: v = 15'd5690;  7'd11: v = 15'd6252;
      7'd12: v = 15'd6813;  7'd13: v = 15'd7371;  7'd14: v = 15'd7927;
      7'd15: v = 15'd8481;  7'd16: v = 15'd9032;  7'd17: v = 15'd9580;
      7'd18: v = 15'd10126; 7'd19: v = 15'd10668; 7'd20: v = 15'd11207;
      7'd21: v = 15'd11743; 7'd22: v = 15'd12275; 7'd23: v = 15'd12803;
      7'd24: v = 15'd13328; 7'd25: v = 15'd13848; 7'd26: v = 15'd14364;
      7'd27: v = 15'd14876; 7'd28: v = 15'd15383; 7'd29: v = 15'd15886;
      7'd30: v = 15'd16384; 7'd31: v = 15'd16876; 7'd32: v = 15'd17364;
      7'd33: v = 15'd17846; 7'd34: v = 15'd18323; 7'd35: v = 15'd18794;
      7'd36: v = 15'd19260; 7'd37: v = 15'd19720; 7'd38: v = 15'd20173;
      7'd39: v = 15'd20621; 7'd40: v = 15'd21062; 7'd41: v = 15'd21497;
      7'd42: v = 15'd21925; 7'd43: v = 15'd22347; 7'd44: v = 15'd22762;
      7'd45: v = 15'd23170; 7'd46: v = 15'd23571; 7'd47: v = 15'd23964;
      7'd48: v = 15'd24351; 7'd49: v = 15'd24730; 7'd50: v = 15'd25101;
      7'd51: v = 15'd25465; 7'd52: v = 15'd25821; 7'd53: v = 15'd26169;
      7'd54: v = 15'd26509; 7'd55: v = 15'd26841; 7'd56: v = 15'd27165;
      7'd57: v = 15'd27481; 7'd58: v = 15'd27788; 7'd59: v = 15'd28087;
      7'd60: v = 15'd28377; 7'd61: v = 15'd28659; 7'd62: v = 15'd28932;
      7'd63: v = 15'd29196; 7'd64: v = 15'd29451; 7'd65: v = 15'd29697;
      7'd66: v = 15'd29934; 7'd67: v = 15'd30162; 7'd68: v = 15'd30381;
      7'd69: v = 15'd30591; 7'd70: v = 15'd30791; 7'd71: v = 15'd30982;
      7'd72: v = 15'd31163; 7'd73: v = 15'd31335; 7'd74: v = 15'd31498;
      7'd75: v = 15'd31650; 7'd76: v = 15'd31794; 7'd77: v = 15'd31927;
      7'd78: v = 15'd32051; 7'd79: v = 15'd32165; 7'd80: v = 15'd32269;
      7'd81: v = 15'd32364; 7'd82: v = 15'd32448; 7'd83: v = 15'd32523;
      7'd84: v = 15'd32587; 7'd85: v = 15'd32642; 7'd86: v = 15'd32687;
      7'd87: v = 15'd32722; 7'd88: v = 15'd32747; 7'd89: v = 15'd32762;
      7'd90: v = 15'd32767;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // sine of a whole-degree angle in 0..359, as sign and magnitude
  function automatic trig_t sin_deg(input logic [BEAM_W-1:0] a);
    trig_t t;
    logic [BEAM_W-1:0] d;
    if (a <= 9'd90) begin
      d = a;
      t.neg = 1'b0;
    end else if (a <= 9'd180) begin
      d = 9'd180 - a;
      t.neg = 1'b0;
    end else if (a <= 9'd270) begin
      d = a - 9'd180;
      t.neg = 1'b1;
    end else begin
      d = 9'd360 - a;
      t.neg = 1'b1;
    end
    t.mag = sine_q15(d[6:0]);
    return t;
  endfunction

endpackage

// ===== src/sog_in_if.sv =====
interface sog_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [sog_pkg::BEAM_W-1:0]    beam_index;
  logic [sog_pkg::RANGE_W-1:0]   range_mm;
  logic [sog_pkg::COORD_W-1:0]   read_x;
  logic [sog_pkg::COORD_W-1:0]   read_y;

  modport source (output valid, mode, beam_index, range_mm, read_x, read_y, input ready);
  modport sink (input valid, mode, beam_index, range_mm, read_x, read_y, output ready);
endinterface

// ===== src/sog_out_if.sv =====
interface sog_out_if;
  logic                               valid;
  logic                               ready;
  logic                               marked;
  logic [sog_pkg::COORD_W-1:0]        cell_x;
  logic [sog_pkg::COORD_W-1:0]        cell_y;
  logic signed [sog_pkg::VALUE_W-1:0] cell_value;

  modport source (output valid, marked, cell_x, cell_y, cell_value, input ready);
  modport sink (input valid, marked, cell_x, cell_y, cell_value, output ready);
endinterface

// ===== src/sog_cfg_if.sv =====
interface sog_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sog_pkg::CFG_IDX_W-1:0]   index;
  logic [sog_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== src/sog_cfg.sv =====
module sog_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [sog_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sog_pkg::CFG_DATA_W-1:0] wr_data,
  output sog_pkg::cfg_t               cfg
);

  sog_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_max_mm <= 16'd6000;
      cfg_r.cell_size_mm <= 16'd250;
      cfg_r.grid_side    <= 7'd48;
      cfg_r.rot_offset   <= 10'sd0;
    end else if (wr_en) begin
      unique case (wr_index)
        sog_pkg::CFG_RANGE_MAX:    cfg_r.range_max_mm <= wr_data;
        sog_pkg::CFG_CELL_SIZE:    cfg_r.cell_size_mm <= wr_data;
        sog_pkg::CFG_GRID_SIDE:    cfg_r.grid_side    <= wr_data[sog_pkg::SIDE_W-1:0];
        sog_pkg::CFG_ANGLE_OFFSET: cfg_r.rot_offset   <= $signed(wr_data[sog_pkg::ANGLE_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/sog_dp.sv =====
module sog_dp (
  input  logic                clk,
  input  sog_pkg::cfg_t       cfg,
  input  sog_pkg::in_item_t   in_item,
  input  sog_pkg::dp_cmd_t    cmd,
  output sog_pkg::dp_stat_t   stat,
  output sog_pkg::out_item_t  out_item
);

  // occupancy bit per cell: 1 = occupied, 0 = unknown
  logic mem [sog_pkg::CELLS];
  logic rd_bit_r;

  sog_pkg::in_item_t  item_r;
  sog_pkg::out_item_t out_r;

  logic [sog_pkg::BEAM_W-1:0]    ang_r;
  sog_pkg::trig_t                sin_r;
  sog_pkg::trig_t                cos_r;
  logic [sog_pkg::RS_W-1:0]      rs_r;
  logic [sog_pkg::NUM_W-1:0]     num_r;
  logic [sog_pkg::DIV_W-1:0]     div_r;
  logic [sog_pkg::DIV_STEPS-1:0] quo_r;
  logic                          neg_r;
  logic [sog_pkg::COORD_W-1:0]   cx_r;
  logic [sog_pkg::COORD_W-1:0]   cy_r;

  logic [sog_pkg::SIDE_W-1:0]  side;
  logic [sog_pkg::SIDE_W-1:0]  side_m1;
  logic                        in_range;
  logic signed [10:0]          ang_sum;
  logic signed [10:0]          ang_wrap;
  logic [9:0]                  cos_arg_w;
  logic [sog_pkg::BEAM_W-1:0]  cos_arg;
  sog_pkg::trig_t              trig_sel;
  logic                        div_ge;
  logic [sog_pkg::DIV_STEPS:0] q_inc;
  logic signed [8:0]           q_signed;
  logic signed [8:0]           q_cell;
  logic [sog_pkg::COORD_W-1:0] q_sat;
  logic [sog_pkg::COORD_W-1:0] rd_x;
  logic [sog_pkg::COORD_W-1:0] rd_y;
  logic [sog_pkg::ADDR_W-1:0]  wr_addr;

  always_comb begin
    if (cfg.grid_side < 7'd2) begin
      side = 7'd2;
    end else if (cfg.grid_side > sog_pkg::SIDE_W'(sog_pkg::GRID_MAX_SIDE)) begin
      side = sog_pkg::SIDE_W'(sog_pkg::GRID_MAX_SIDE);
    end else begin
      side = cfg.grid_side;
    end
    side_m1 = side - 7'd1;
  end

  assign in_range = (item_r.beam_index < sog_pkg::BEAM_W'(sog_pkg::BEAM_COUNT)) &&
                    (cfg.range_max_mm != '0) &&
                    (item_r.range_mm <= cfg.range_max_mm) &&
                    ({1'b0, item_r.range_mm} > {cfg.cell_size_mm, 1'b0});

  assign stat.is_read  = item_r.mode;
  assign stat.in_range = in_range;

  // beam + offset wrapped into 0..359
  always_comb begin
    ang_sum = $signed({2'b00, item_r.beam_index}) +
              $signed({cfg.rot_offset[sog_pkg::ANGLE_W-1], cfg.rot_offset});
    if (ang_sum < -11'sd360) begin
      ang_wrap = ang_sum + 11'sd720;
    end else if (ang_sum < 11'sd0) begin
      ang_wrap = ang_sum + 11'sd360;
    end else if (ang_sum >= 11'sd720) begin
      ang_wrap = ang_sum - 11'sd720;
    end else if (ang_sum >= 11'sd360) begin
      ang_wrap = ang_sum - 11'sd360;
    end else begin
      ang_wrap = ang_sum;
    end
  end

  always_comb begin
    cos_arg_w = {1'b0, ang_r} + 10'd90;
    if (cos_arg_w >= 10'd360) begin
      cos_arg_w = cos_arg_w - 10'd360;
    end
    cos_arg = cos_arg_w[sog_pkg::BEAM_W-1:0];
  end

  // axis 0 is x (cosine), axis 1 is y (sine)
  assign trig_sel = cmd.axis ? sin_r : cos_r;
  assign div_ge   = {{(sog_pkg::NUM_W-sog_pkg::DIV_W){1'b0}}, div_r} <= num_r;

  // floor division with sign, then centre and saturate to the grid
  always_comb begin
    q_inc = {1'b0, quo_r} + {{sog_pkg::DIV_STEPS{1'b0}}, (num_r != '0)};
    if (neg_r) begin
      q_signed = -$signed({{(8-sog_pkg::DIV_STEPS){1'b0}}, q_inc});
    end else begin
      q_signed = $signed({{(9-sog_pkg::DIV_STEPS){1'b0}}, quo_r});
    end
    q_cell = q_signed + $signed({3'b000, side[sog_pkg::SIDE_W-1:1]});
    if (q_cell < 9'sd0) begin
      q_sat = '0;
    end else if (q_cell > $signed({2'b00, side_m1})) begin
      q_sat = side_m1[sog_pkg::COORD_W-1:0];
    end else begin
      q_sat = q_cell[sog_pkg::COORD_W-1:0];
    end
  end

  always_comb begin
    rd_x = ({1'b0, item_r.read_x} > side_m1) ? side_m1[sog_pkg::COORD_W-1:0] : item_r.read_x;
    rd_y = ({1'b0, item_r.read_y} > side_m1) ? side_m1[sog_pkg::COORD_W-1:0] : item_r.read_y;
  end

  assign wr_addr = (cmd.op == sog_pkg::OP_CLEAR) ? cmd.clr_addr : {cy_r, cx_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    unique case (cmd.op)
      sog_pkg::OP_NOP: ;
      sog_pkg::OP_ANGLE: begin
        ang_r <= ang_wrap[sog_pkg::BEAM_W-1:0];
      end
      sog_pkg::OP_TRIG: begin
        sin_r <= sog_pkg::sin_deg(ang_r);
        cos_r <= sog_pkg::sin_deg(cos_arg);
        rs_r  <= {{sog_pkg::SIDE_W{1'b0}}, item_r.range_mm} *
                 {{sog_pkg::RANGE_W{1'b0}}, side};
      end
      sog_pkg::OP_MUL: begin
        num_r <= {{sog_pkg::TRIG_W{1'b0}}, rs_r} * {{sog_pkg::RS_W{1'b0}}, trig_sel.mag};
        neg_r <= trig_sel.neg;
        div_r <= {cfg.range_max_mm, {(sog_pkg::DIV_W-sog_pkg::RANGE_W){1'b0}}};
        quo_r <= '0;
      end
      sog_pkg::OP_DIV: begin
        if (div_ge) begin
          num_r <= num_r - {{(sog_pkg::NUM_W-sog_pkg::DIV_W){1'b0}}, div_r};
        end
        quo_r <= {quo_r[sog_pkg::DIV_STEPS-2:0], div_ge};
        div_r <= div_r >> 1;
      end
      sog_pkg::OP_FIN: begin
        if (cmd.axis) begin
          cy_r <= q_sat;
        end else begin
          cx_r <= q_sat;
        end
      end
      sog_pkg::OP_MARK: begin
        mem[wr_addr] <= 1'b1;
      end
      sog_pkg::OP_READ: begin
        rd_bit_r <= mem[{rd_y, rd_x}];
        cx_r     <= rd_x;
        cy_r     <= rd_y;
      end
      sog_pkg::OP_CLEAR: begin
        mem[wr_addr] <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      if (item_r.mode) begin
        out_r.marked     <= 1'b0;
        out_r.cell_x     <= cx_r;
        out_r.cell_y     <= cy_r;
        out_r.cell_value <= rd_bit_r ? sog_pkg::CELL_OCCUPIED : sog_pkg::CELL_UNKNOWN;
      end else if (in_range) begin
        out_r.marked     <= 1'b1;
        out_r.cell_x     <= cx_r;
        out_r.cell_y     <= cy_r;
        out_r.cell_value <= sog_pkg::CELL_OCCUPIED;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_item = out_r;

endmodule

// ===== src/sog_ctrl.sv =====
module sog_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sog_pkg::dp_stat_t stat,
  output sog_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_TRIG,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_MARK,
    ST_READ,
    ST_DONE
  } state_t;

  state_t                        state_r;
  logic                          axis_r;
  logic [sog_pkg::STEP_W-1:0]    step_r;
  logic [sog_pkg::ADDR_W-1:0]    clr_cnt_r;
  logic                          out_valid_r;
  logic                          out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.load     = in_valid && in_ready;
    cmd.axis     = axis_r;
    cmd.clr_addr = clr_cnt_r;
    cmd.out_load = (state_r == ST_DONE) && out_free;
    unique case (state_r)
      ST_CLEAR: cmd.op = sog_pkg::OP_CLEAR;
      ST_CHECK: cmd.op = sog_pkg::OP_ANGLE;
      ST_TRIG:  cmd.op = sog_pkg::OP_TRIG;
      ST_MUL:   cmd.op = sog_pkg::OP_MUL;
      ST_DIV:   cmd.op = sog_pkg::OP_DIV;
      ST_FIN:   cmd.op = sog_pkg::OP_FIN;
      ST_MARK:  cmd.op = sog_pkg::OP_MARK;
      ST_READ:  cmd.op = sog_pkg::OP_READ;
      default:  cmd.op = sog_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      axis_r      <= 1'b0;
      step_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stat.is_read) begin
            state_r <= ST_READ;
          end else if (stat.in_range) begin
            state_r <= ST_TRIG;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_TRIG: begin
          axis_r  <= 1'b0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          step_r  <= sog_pkg::STEP_W'(sog_pkg::DIV_STEPS - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (axis_r) begin
            state_r <= ST_MARK;
          end else begin
            axis_r  <= 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_MARK: state_r <= ST_DONE;
        ST_READ: state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("item taken during clearing pass");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_CHECK)
    else $error("accepted word did not start processing");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && step_r == '0 |=> state_r == ST_FIN)
    else $error("division ran past its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("result register overwritten while held");

  a_mark_second_axis: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MARK |-> axis_r)
    else $error("cell marked before both axes done");

endmodule

// ===== src/scan_to_occupancy_grid.sv =====
// polar range scan to occupancy grid
// in_chan carries one word per beam: mode 0 maps a range sample (beam_index in
// degrees, range_mm), mode 1 reads back the cell at read_x, read_y (clamped to
// the grid side in use). out_chan returns exactly one word per input word:
// marked, cell_x, cell_y and cell_value (99 occupied, -1 unknown, 0 when a
// sample is out of range). cfg_chan writes range_max_mm, cell_size_mm,
// grid_side and the rotation offset (index 0..3); it is always ready and must
// only be used while the block is idle.
// one word is processed at a time. a mapped sample works the two axes one
// after the other, sharing one multiplier and a 5-step restoring divider; a
// read passes only the check and read states, an out-of-range sample only the
// check state. the grid is a 4096 x 1 memory, one read or write port per cycle.
// after reset the block sweeps every cell of the grid to unknown with
// in_chan.ready low; configuration writes are taken meanwhile.
// the result sits in an output register: while the receiver stalls, the next
// word may still be accepted and worked on; it then waits until the register
// is free.
module scan_to_occupancy_grid (
  input  logic      clk,
  input  logic      rst_n,
  sog_in_if.sink    in_chan,
  sog_out_if.source out_chan,
  sog_cfg_if.sink   cfg_chan
);

  sog_pkg::cfg_t      cfg;
  sog_pkg::in_item_t  in_item;
  sog_pkg::out_item_t out_item;
  sog_pkg::dp_cmd_t   cmd;
  sog_pkg::dp_stat_t  stat;

  assign cfg_chan.ready = 1'b1;

  assign in_item.mode       = in_chan.mode;
  assign in_item.beam_index = in_chan.beam_index;
  assign in_item.range_mm   = in_chan.range_mm;
  assign in_item.read_x     = in_chan.read_x;
  assign in_item.read_y     = in_chan.read_y;

  assign out_chan.marked     = out_item.marked;
  assign out_chan.cell_x     = out_item.cell_x;
  assign out_chan.cell_y     = out_item.cell_y;
  assign out_chan.cell_value = out_item.cell_value;

  sog_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.wdata),
    .cfg      (cfg)
  );

  sog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sog_dp u_dp (
    .clk      (clk),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// ===== tb/grid_checker.sv =====
`timescale 1ns / 100ps

module grid_checker
  import sog_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sog_in_if    in_mon,
  sog_out_if   out_mon,
  sog_cfg_if   cfg_mon,
  output int   failures,
  output int   pending
);

  localparam int DEG_FULL = 360;

  // round(32767 * sin(d)) for d = 0..90 degrees
  localparam int QUARTER_SINE [91] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14364, 14876, 15383, 15886,
    16384, 16876, 17364, 17846, 18323, 18794, 19260, 19720, 20173, 20621,
    21062, 21497, 21925, 22347, 22762, 23170, 23571, 23964, 24351, 24730,
    25101, 25465, 25821, 26169, 26509, 26841, 27165, 27481, 27788, 28087,
    28377, 28659, 28932, 29196, 29451, 29697, 29934, 30162, 30381, 30591,
    30791, 30982, 31163, 31335, 31498, 31650, 31794, 31927, 32051, 32165,
    32269, 32364, 32448, 32523, 32587, 32642, 32687, 32722, 32747, 32762,
    32767
  };

  logic [RANGE_W-1:0]        range_max;
  logic [RANGE_W-1:0]        cell_size;
  logic [6:0]                side_reg;
  logic signed [ANGLE_W-1:0] offset_deg;
  logic signed [VALUE_W-1:0] grid_map [CELLS];

  out_item_t expected_cells [$];
  out_item_t want;
  in_item_t  word;
  int        fail_count;

  assign failures = fail_count;

  task automatic report_fault(input string what);
    $display("[%0t] %s", $time, what);
    fail_count++;
  endtask

  function automatic int side_eff();
    if (side_reg < 7'd2) return 2;
    if (side_reg > 7'(GRID_MAX_SIDE)) return GRID_MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic int q15_sine(input int a);
    if (a <= 90) return QUARTER_SINE[a];
    if (a <= 180) return QUARTER_SINE[180 - a];
    if (a <= 270) return -QUARTER_SINE[a - 180];
    return -QUARTER_SINE[DEG_FULL - a];
  endfunction

  // floor(r * t * side / (2 * range_max * 2^15) + side / 2), clamped to the grid
  function automatic int axis_cell(input longint r, input longint t, input int side);
    longint den;
    longint num;
    longint q;
    den = longint'(range_max) * 65536;
    num = r * t * side + longint'(side / 2) * den;
    if (num < 0) return 0;
    q = num / den;
    if (q > side - 1) q = side - 1;
    return int'(q);
  endfunction

  function automatic out_item_t apply_word(input in_item_t w);
    out_item_t res;
    int side;
    int a;
    int cx;
    int cy;
    res = '0;
    side = side_eff();
    if (w.mode) begin
      cx = int'(w.read_x);
      cy = int'(w.read_y);
      if (cx > side - 1) cx = side - 1;
      if (cy > side - 1) cy = side - 1;
      res.cell_x = COORD_W'(cx);
      res.cell_y = COORD_W'(cy);
      res.cell_value = grid_map[cy * GRID_MAX_SIDE + cx];
    end else if (int'(w.beam_index) < BEAM_COUNT && range_max != 0 &&
                 w.range_mm <= range_max && int'(w.range_mm) > 2 * int'(cell_size)) begin
      a = (int'(w.beam_index) + int'(offset_deg)) % DEG_FULL;
      if (a < 0) a += DEG_FULL;
      cx = axis_cell(longint'(w.range_mm), longint'(q15_sine((a + 90) % DEG_FULL)), side);
      cy = axis_cell(longint'(w.range_mm), longint'(q15_sine(a)), side);
      grid_map[cy * GRID_MAX_SIDE + cx] = CELL_OCCUPIED;
      res.marked = 1'b1;
      res.cell_x = COORD_W'(cx);
      res.cell_y = COORD_W'(cy);
      res.cell_value = CELL_OCCUPIED;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      range_max  = 16'd6000;
      cell_size  = 16'd250;
      side_reg   = 7'd48;
      offset_deg = '0;
      for (int i = 0; i < CELLS; i++) grid_map[i] = CELL_UNKNOWN;
      expected_cells.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_RANGE_MAX:    range_max  = cfg_mon.wdata;
          CFG_CELL_SIZE:    cell_size  = cfg_mon.wdata;
          CFG_GRID_SIDE:    side_reg   = cfg_mon.wdata[6:0];
          CFG_ANGLE_OFFSET: offset_deg = cfg_mon.wdata[ANGLE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        word.mode       = in_mon.mode;
        word.beam_index = in_mon.beam_index;
        word.range_mm   = in_mon.range_mm;
        word.read_x     = in_mon.read_x;
        word.read_y     = in_mon.read_y;
        expected_cells.push_back(apply_word(word));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_cells.size() == 0) begin
          report_fault("result word with nothing expected");
        end else begin
          want = expected_cells.pop_front();
          if (out_mon.marked !== want.marked)
            report_fault($sformatf("marked: got %0b expected %0b", out_mon.marked,
                                   want.marked));
          if (out_mon.cell_x !== want.cell_x)
            report_fault($sformatf("cell_x: got %0d expected %0d", out_mon.cell_x,
                                   want.cell_x));
          if (out_mon.cell_y !== want.cell_y)
            report_fault($sformatf("cell_y: got %0d expected %0d", out_mon.cell_y,
                                   want.cell_y));
          if (out_mon.cell_value !== want.cell_value)
            report_fault($sformatf("cell_value: got %0d expected %0d",
                                   out_mon.cell_value, want.cell_value));
        end
      end
    end
    pending = expected_cells.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sog_pkg::*;

  localparam int CYCLE_LIMIT    = 400_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 144;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  int   failures;
  int   pending;
  int   cycle_count = 0;

  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_taken = 1'b0;

  int cur_rm   = 6000;
  int cur_cs   = 250;
  int cur_side = 48;

  sog_in_if  scan_if ();
  sog_out_if cell_if ();
  sog_cfg_if cfg_if ();

  scan_to_occupancy_grid u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (scan_if),
    .out_chan (cell_if),
    .cfg_chan (cfg_if)
  );

  grid_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (scan_if),
    .out_mon  (cell_if),
    .cfg_mon  (cfg_if),
    .failures (failures),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    cell_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        cell_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        cell_if.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  function automatic int side_in_use();
    if (cur_side < 2) return 2;
    if (cur_side > GRID_MAX_SIDE) return GRID_MAX_SIDE;
    return cur_side;
  endfunction

  function automatic in_item_t sample_word(input int beam, input int r);
    in_item_t w;
    w = '0;
    w.beam_index = BEAM_W'(beam);
    w.range_mm = RANGE_W'(r);
    return w;
  endfunction

  function automatic in_item_t read_word(input int x, input int y);
    in_item_t w;
    w = '0;
    w.mode = 1'b1;
    w.read_x = COORD_W'(x);
    w.read_y = COORD_W'(y);
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t w;
    int roll;
    int lo;
    w.mode = 1'b0;
    w.beam_index = BEAM_W'($urandom_range(359));
    w.range_mm = RANGE_W'($urandom);
    w.read_x = COORD_W'($urandom);
    w.read_y = COORD_W'($urandom);
    roll = $urandom_range(99);
    lo = 2 * cur_cs + 1;
    if (roll < 62) begin
      if (lo <= cur_rm) w.range_mm = RANGE_W'($urandom_range(cur_rm, lo));
    end else if (roll < 70) begin
      w.beam_index = BEAM_W'($urandom_range(511));
    end else if (roll < 76) begin
      // range right at either acceptance edge
      case ($urandom_range(3))
        0: w.range_mm = RANGE_W'(lo - 1);
        1: w.range_mm = RANGE_W'(lo);
        2: w.range_mm = RANGE_W'(cur_rm);
        default: w.range_mm = RANGE_W'(cur_rm + 1);
      endcase
    end else begin
      w.mode = 1'b1;
      if (roll < 94) begin
        w.read_x = COORD_W'($urandom_range(side_in_use() - 1));
        w.read_y = COORD_W'($urandom_range(side_in_use() - 1));
      end
    end
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input in_item_t w);
    while (!calm && $urandom_range(99) < 8) begin
      scan_if.valid <= 1'b0;
      @(negedge clk);
    end
    scan_if.valid      <= 1'b1;
    scan_if.mode       <= w.mode;
    scan_if.beam_index <= w.beam_index;
    scan_if.range_mm   <= w.range_mm;
    scan_if.read_x     <= w.read_x;
    scan_if.read_y     <= w.read_y;
    do @(posedge clk); while (!scan_if.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    scan_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_grid_cfg(input int rm, input int cs, input int side, input int off,
                              input bit poke_unused);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    int n;
    idx = '{CFG_RANGE_MAX, CFG_CELL_SIZE, CFG_GRID_SIDE, CFG_ANGLE_OFFSET, CFG_UNUSED_IDX};
    val = '{16'(rm), 16'(cs), 16'(side & 'h7F), 16'(off & 'h3FF), 16'd7};
    n = poke_unused ? 5 : 4;
    drain_results();
    for (int i = 0; i < n; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.wdata <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
    cur_rm = rm & 'hFFFF;
    cur_cs = cs & 'hFFFF;
    cur_side = side & 'h7F;
  endtask

  initial begin
    int rm;
    rst_n              <= 1'b0;
    scan_if.valid      <= 1'b0;
    scan_if.mode       <= 1'b0;
    scan_if.beam_index <= '0;
    scan_if.range_mm   <= '0;
    scan_if.read_x     <= '0;
    scan_if.read_y     <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.wdata       <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, both acceptance edges, all quadrants, bad beams
    set_grid_cfg(6000, 250, 48, 0, 1'b1);
    send_word(sample_word(0, 6000));
    send_word(sample_word(90, 6000));
    send_word(sample_word(180, 6000));
    send_word(sample_word(270, 501));
    send_word(sample_word(359, 3000));
    send_word(sample_word(45, 500));
    send_word(sample_word(10, 0));
    send_word(sample_word(10, 6001));
    send_word(sample_word(10, 65535));
    send_word(sample_word(360, 3000));
    send_word(sample_word(511, 3000));
    send_word(read_word(47, 24));
    send_word(read_word(0, 0));
    send_word(read_word(63, 63));

    // negative offset wraps, side above the maximum acts as the maximum
    set_grid_cfg(65535, 1, 127, -359, 1'b0);
    send_word(sample_word(0, 65535));
    send_word(read_word(63, 63));

    // positive offset wraps, odd side pushes the far negative edge below zero
    set_grid_cfg(1000, 100, 3, 359, 1'b0);
    send_word(sample_word(359, 1000));
    send_word(sample_word(181, 1000));
    send_word(read_word(63, 0));

    // zero range maximum, side below the minimum
    set_grid_cfg(0, 1, 1, 0, 1'b0);
    send_word(sample_word(0, 0));
    send_word(sample_word(0, 1));
    send_word(read_word(5, 5));

    for (int ph = 0; ph < PHASES; ph++) begin
      rm = $urandom_range(65535, 16);
      case (ph)
        0: set_grid_cfg(6000, 250, 48, 0, 1'b0);
        1: set_grid_cfg(65535, 1, 64, 359, 1'b0);
        2: set_grid_cfg(3, 1, 2, -359, 1'b0);
        5: set_grid_cfg(rm, $urandom_range(rm / 8, 1), 127, -512, 1'b1);
        6: set_grid_cfg(rm, $urandom_range(rm / 8, 1), 0, 511, 1'b0);
        7: set_grid_cfg(0, 65535, 1, 0, 1'b0);
        default: set_grid_cfg(rm, $urandom_range(rm / 8, 1), $urandom_range(64, 2),
                              $urandom_range(718) - 359, 1'b0);
      endcase
      calm = (ph == 1);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (ph == 3 && i == 40) hold_go = 1'b1;
        if (ph == 4 && i == 70) drain_results();
        send_word(random_word());
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
